[src/npc_pkg.sv]
package npc_pkg;

  // palette size and derived widths
  localparam int PaletteEntries = 256;
  localparam int AddrW          = $clog2(PaletteEntries);
  localparam int CntW           = $clog2(PaletteEntries + 1);

  // item field widths
  localparam int ColorW     = 8;
  localparam int EntryIdxW  = 8;
  localparam int EntryW     = 3 * ColorW;
  localparam int SqW        = 2 * ColorW;
  localparam int DistW      = 18;
  localparam int InDataW    = 32;
  localparam int OutDataW   = 32;

  // starting value of the running minimum, above any real distance
  localparam logic [DistW-1:0] WorstDistance = DistW'(257 * 257 * 3);
  localparam logic [AddrW-1:0] LastIdx       = AddrW'(PaletteEntries - 1);

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

endpackage

[src/npc_ram.sv]
module npc_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/nearest_palette_color_core.sv]
// a write item is written to the palette ram on its handshake and gives no result
// a query scans one palette entry per cycle through the palette ram read port:
//   the result follows the ram read, squares and sum-and-compare stages, sooner
//   on an exact match, later while an earlier result is still unclaimed
// a query holds off new items until its result is loaded; one write per cycle while idle
// reset (rst_ni low, asynchronous): control and output valid cleared,
//   palette contents are kept and stay undefined until written
module nearest_palette_color_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // tdata from bit 0: entry_index[7:0], red[7:0], green[7:0], blue[7:0]
  input  logic [npc_pkg::InDataW-1:0]  s_axis_tdata_i,
  // tuser: action (0 write entry, 1 query)
  input  logic                         s_axis_tuser_i,
  // result items
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // tdata from bit 0: best_index[7:0], best_distance[17:0], zero pad[5:0]
  output logic [npc_pkg::OutDataW-1:0] m_axis_tdata_o,
  // tuser: exact_match
  output logic                         m_axis_tuser_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e state_q;

  // unpacked input fields
  logic [npc_pkg::EntryIdxW-1:0] in_idx;
  logic [npc_pkg::ColorW-1:0]    in_red, in_green, in_blue;
  logic                          in_acc;
  logic                          pal_we;

  assign in_idx   = s_axis_tdata_i[7:0];
  assign in_red   = s_axis_tdata_i[15:8];
  assign in_green = s_axis_tdata_i[23:16];
  assign in_blue  = s_axis_tdata_i[31:24];

  // query color held for the whole scan
  logic [npc_pkg::ColorW-1:0] q_red_q, q_green_q, q_blue_q;

  // scan address counter, one wider so it can hold the entry count
  logic [npc_pkg::CntW-1:0]  cnt_q;
  logic                      issue;

  // pipeline: ram read (stage 1), squares (stage 2), sum and compare
  logic                      v1_q, v2_q;
  logic [npc_pkg::AddrW-1:0] idx1_q, idx2_q;
  logic [npc_pkg::EntryW-1:0] rd_entry;
  logic [npc_pkg::ColorW-1:0] e_red, e_green, e_blue;
  logic [npc_pkg::ColorW-1:0] d_red, d_green, d_blue;
  logic [npc_pkg::SqW-1:0]    sq_red_q, sq_green_q, sq_blue_q;
  logic [npc_pkg::DistW-1:0]  cand_dist;

  // running best
  logic [npc_pkg::DistW-1:0]  best_dist_q;
  logic [npc_pkg::AddrW-1:0]  best_idx_q;
  logic                       better;
  logic                       hit;
  logic                       scan_end;

  // output register
  logic                          m_valid_q;
  logic [npc_pkg::OutDataW-1:0]  m_data_q;
  logic                          m_user_q;
  logic                          out_free;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // writes beyond the palette are dropped
  assign pal_we = in_acc && (s_axis_tuser_i == npc_pkg::ACT_WRITE)
               && (32'(in_idx) < npc_pkg::PaletteEntries);

  assign issue = (state_q == ST_SCAN) && (cnt_q < npc_pkg::CntW'(npc_pkg::PaletteEntries));

  npc_ram #(
    .Width(npc_pkg::EntryW),
    .Depth(npc_pkg::PaletteEntries)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (pal_we),
    .waddr_i(npc_pkg::AddrW'(in_idx)),
    .wdata_i({in_red, in_green, in_blue}),
    .re_i   (issue),
    .raddr_i(cnt_q[npc_pkg::AddrW-1:0]),
    .rdata_o(rd_entry)
  );

  // entry layout: red high, blue low
  assign e_red   = rd_entry[23:16];
  assign e_green = rd_entry[15:8];
  assign e_blue  = rd_entry[7:0];

  always_comb begin
    d_red   = (q_red_q   > e_red)   ? (q_red_q   - e_red)   : (e_red   - q_red_q);
    d_green = (q_green_q > e_green) ? (q_green_q - e_green) : (e_green - q_green_q);
    d_blue  = (q_blue_q  > e_blue)  ? (q_blue_q  - e_blue)  : (e_blue  - q_blue_q);
  end

  assign cand_dist = npc_pkg::DistW'(sq_red_q) + npc_pkg::DistW'(sq_green_q)
                   + npc_pkg::DistW'(sq_blue_q);

  // strict less keeps the lowest index on ties
  assign better   = v2_q && (state_q == ST_SCAN) && (cand_dist < best_dist_q);
  assign hit      = better && (cand_dist == '0);
  assign scan_end = v2_q && (state_q == ST_SCAN) && (hit || (idx2_q == npc_pkg::LastIdx));
  assign out_free = !m_valid_q || m_axis_tready_i;

  // datapath stages, no reset needed
  always_ff @(posedge clk_i) begin
    idx1_q     <= cnt_q[npc_pkg::AddrW-1:0];
    idx2_q     <= idx1_q;
    sq_red_q   <= npc_pkg::SqW'(d_red)   * npc_pkg::SqW'(d_red);
    sq_green_q <= npc_pkg::SqW'(d_green) * npc_pkg::SqW'(d_green);
    sq_blue_q  <= npc_pkg::SqW'(d_blue)  * npc_pkg::SqW'(d_blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      best_dist_q <= npc_pkg::WorstDistance;
      best_idx_q  <= '0;
      q_red_q     <= '0;
      q_green_q   <= '0;
      q_blue_q    <= '0;
      m_valid_q   <= 1'b0;
      m_data_q    <= '0;
      m_user_q    <= 1'b0;
    end else begin
      // in-flight reads die once the scan has ended
      v1_q <= issue;
      v2_q <= v1_q && (state_q == ST_SCAN);

      // in finish the output register is reloaded instead
      if (m_valid_q && m_axis_tready_i && (state_q != ST_FINISH)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc && (s_axis_tuser_i == npc_pkg::ACT_QUERY)) begin
            state_q     <= ST_SCAN;
            cnt_q       <= '0;
            best_dist_q <= npc_pkg::WorstDistance;
            best_idx_q  <= '0;
            q_red_q     <= in_red;
            q_green_q   <= in_green;
            q_blue_q    <= in_blue;
          end
        end
        ST_SCAN: begin
          if (issue) begin
            cnt_q <= cnt_q + npc_pkg::CntW'(1);
          end
          if (better) begin
            best_dist_q <= cand_dist;
            best_idx_q  <= idx2_q;
          end
          if (scan_end) begin
            state_q <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // wait here while the previous result is still unclaimed
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {6'd0, best_dist_q, 8'(best_idx_q)};
            m_user_q  <= (best_dist_q == '0);
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTHESIS
  // a waiting result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && m_valid_q && !m_axis_tready_i) |=> state_q == ST_FINISH)
    else $error("result overwritten while output stalled");

  // an exact match ends the scan at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit |=> state_q == ST_FINISH)
    else $error("scan continued past exact match");

  // the scan counter never runs past the palette
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= npc_pkg::CntW'(npc_pkg::PaletteEntries))
    else $error("scan counter overrun");

  // the running minimum never grows during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && $past(state_q) == ST_SCAN) |-> best_dist_q <= $past(best_dist_q))
    else $error("best distance increased");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import npc_pkg::*;

  localparam int MaxCycles   = 2_000_000;
  localparam int LongHold    = 3000;
  localparam int DrainCycles = PaletteEntries + 16;

  // one nearest-color answer as the block reports it
  typedef struct packed {
    logic [EntryIdxW-1:0] index;
    logic [DistW-1:0]     distance;
    logic                 exact;
  } match_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  // tdata from bit 0: entry_index, red, green, blue
  logic [InDataW-1:0]  s_axis_tdata_i;
  // tuser: action
  logic                s_axis_tuser_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  // tdata from bit 0: best_index, best_distance, zero pad
  logic [OutDataW-1:0] m_axis_tdata_o;
  // tuser: exact_match
  logic                m_axis_tuser_o;

  nearest_palette_color_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // palette as the block should hold it, red in the top byte
  logic [EntryW-1:0] palette_copy [PaletteEntries];
  match_t            pending_matches [$];

  int error_count;
  int cycle_count;
  int query_count;
  int write_count;
  int result_count;
  int exact_count;
  int hold_left;
  bit tx_idle_on;
  bit rx_idle_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // scan from index 0, keep strictly smaller distances, stop on distance zero
  function automatic match_t nearest_entry(logic [EntryW-1:0] want_rgb);
    match_t            m;
    logic [EntryW-1:0] e;
    int                best_d;
    int                best_k;
    int                d;
    int                dr;
    int                dg;
    int                db;
    best_d = 257 * 257 * 3;
    best_k = 0;
    for (int k = 0; k < PaletteEntries; k++) begin
      e  = palette_copy[k];
      dr = int'(want_rgb[2*ColorW +: ColorW]) - int'(e[2*ColorW +: ColorW]);
      dg = int'(want_rgb[ColorW +: ColorW]) - int'(e[ColorW +: ColorW]);
      db = int'(want_rgb[0 +: ColorW]) - int'(e[0 +: ColorW]);
      d  = dr * dr + dg * dg + db * db;
      if (d < best_d) begin
        best_d = d;
        best_k = k;
        if (d == 0) break;
      end
    end
    m.index    = EntryIdxW'(best_k);
    m.distance = DistW'(best_d);
    m.exact    = (best_d == 0);
    return m;
  endfunction

  // mostly full-range colors, some from a coarse grid so that ties occur
  function automatic logic [EntryW-1:0] random_color();
    logic [ColorW-1:0] c [3];
    int                mode;
    int                q;
    mode = $urandom_range(0, 9);
    for (int j = 0; j < 3; j++) begin
      q = $urandom_range(0, 4);
      if (mode == 0) c[j] = $urandom_range(0, 1) ? '1 : '0;
      else if (mode <= 3) c[j] = (q == 4) ? '1 : ColorW'(q * 64);
      else c[j] = ColorW'($urandom);
    end
    return {c[0], c[1], c[2]};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch in %s at result %0d: got %0d, expected %0d",
             what, result_count, got, want);
    error_count++;
  endtask

  // offer one item, wait for its handshake, then update the prediction
  task automatic send_item(action_e act, logic [EntryIdxW-1:0] idx,
                           logic [EntryW-1:0] rgb);
    int gap;
    @(negedge clk_i);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= act;
    s_axis_tdata_i  <= {rgb[0 +: ColorW], rgb[ColorW +: ColorW],
                        rgb[2*ColorW +: ColorW], idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    if (act == ACT_WRITE) begin
      palette_copy[idx] = rgb;
      write_count++;
    end else begin
      pending_matches.push_back(nearest_entry(rgb));
      query_count++;
    end
  endtask

  task automatic fill_uniform(logic [EntryW-1:0] rgb);
    for (int k = 0; k < PaletteEntries; k++)
      send_item(ACT_WRITE, EntryIdxW'(k), rgb);
  endtask

  // all entries black: white is at the largest distance, every entry ties
  task automatic test_uniform_black();
    fill_uniform('0);
    send_item(ACT_QUERY, '1, '1);
    send_item(ACT_QUERY, '0, '0);
    send_item(ACT_QUERY, 8'h5a, 24'hff00ff);
    send_item(ACT_QUERY, 8'ha5, 24'h00ff00);
  endtask

  // duplicates and equal distances, black stored only at the last entry
  task automatic test_tie_break();
    fill_uniform('1);
    send_item(ACT_WRITE, 8'd40, 24'h646464);
    send_item(ACT_WRITE, 8'd41, 24'h646464);
    send_item(ACT_WRITE, 8'd128, 24'h626464);
    send_item(ACT_WRITE, 8'd130, 24'h666464);
    send_item(ACT_WRITE, LastIdx, 24'h000000);
    send_item(ACT_QUERY, 8'd0, 24'h646464);
    send_item(ACT_QUERY, 8'd1, 24'h645a64);
    send_item(ACT_QUERY, 8'd2, 24'h656464);
    send_item(ACT_QUERY, 8'd3, 24'h000000);
    send_item(ACT_QUERY, 8'd4, 24'h010000);
    send_item(ACT_QUERY, 8'd5, 24'hffffff);
    send_item(ACT_QUERY, 8'd6, 24'hff0000);
  endtask

  task automatic test_random_palette();
    for (int k = 0; k < PaletteEntries; k++)
      send_item(ACT_WRITE, EntryIdxW'(k), random_color());
  endtask

  // mixed writes and queries; a third of the queries ask for a stored color
  task automatic test_random_traffic(int n_items, int query_pct);
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 99) < query_pct) begin
        if ($urandom_range(0, 2) == 0)
          send_item(ACT_QUERY, EntryIdxW'($urandom),
                    palette_copy[$urandom_range(0, PaletteEntries - 1)]);
        else
          send_item(ACT_QUERY, EntryIdxW'($urandom), random_color());
      end else begin
        send_item(ACT_WRITE, EntryIdxW'($urandom), random_color());
      end
    end
  endtask

  // receiver holds off for a long stretch while queries keep coming
  task automatic test_output_stall();
    hold_left = LongHold;
    for (int i = 0; i < 12; i++) begin
      if (i % 3 == 2)
        send_item(ACT_WRITE, EntryIdxW'($urandom), random_color());
      else
        send_item(ACT_QUERY, EntryIdxW'($urandom), random_color());
    end
  endtask

  task automatic test_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    test_random_traffic(240, 50);
  endtask

  // result side ready: long hold first, then random stall bursts
  initial begin : result_sink
    int burst;
    burst = 0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready_i <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 9) - 1;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    match_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      result_count++;
      if (m_axis_tuser_o) exact_count++;
      if (pending_matches.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_matches.pop_front();
        if (m_axis_tdata_o[7:0] !== want.index)
          report_mismatch("best_index", int'(m_axis_tdata_o[7:0]), int'(want.index));
        if (m_axis_tdata_o[25:8] !== want.distance)
          report_mismatch("best_distance", int'(m_axis_tdata_o[25:8]),
                          int'(want.distance));
        if (m_axis_tuser_o !== want.exact)
          report_mismatch("exact_match", int'(m_axis_tuser_o), int'(want.exact));
        if (m_axis_tdata_o[31:26] !== '0)
          report_mismatch("tdata pad", int'(m_axis_tdata_o[31:26]), 0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= MaxCycles) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_matches.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = ACT_WRITE;
    m_axis_tready_i = 1'b0;
    tx_idle_on      = 1'b1;
    rx_idle_on      = 1'b1;
    hold_left       = 0;
    error_count     = 0;
    cycle_count     = 0;
    query_count     = 0;
    write_count     = 0;
    result_count    = 0;
    exact_count     = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_uniform_black();
    test_tie_break();
    test_random_palette();
    test_random_traffic(210, 45);
    test_output_stall();
    test_no_idle();

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d palette writes and %0d queries sent, %0d results checked, %0d exact",
             write_count, query_count, result_count, exact_count);
    $display("uniform and tied palettes, random traffic with stalls, long output hold");
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[nearest_palette_color_core.f]
src/npc_pkg.sv
src/npc_ram.sv
src/nearest_palette_color_core.sv
tb/sv/testbench.sv
